@@ sv/lcsa_pkg.sv @@
// Shared constants, types and codes for the load cell scale and average block.
`default_nettype none

package lcsa_pkg;

    localparam int RAW_W      = 24;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int SCALE_W    = 32;
    localparam int FORCE_W    = 32;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = FORCE_W + ADDR_W;

    // Serial multiplier: one bit of the offset-corrected count per cycle.
    localparam int ACC_W      = SCALE_W + 2;
    localparam int MUL_STEPS  = DIFF_W;
    localparam int MCNT_W     = $clog2(MUL_STEPS + 1);
    localparam int FRAC_SHIFT = 8;
    localparam int Q_W        = ACC_W + DIFF_W - FRAC_SHIFT;

    // Serial divider: one quotient bit per cycle.
    localparam int DIV_STEPS  = SUM_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(32'h0100_0000);
    localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(1);
    localparam logic [FORCE_W-1:0] FORCE_MAX    = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN    = {1'b1, {(FORCE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_OFFSET  = 2'd0,
        REG_SCALE_FACTOR = 2'd1,
        REG_WINDOW_SIZE  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_SUB,
        ST_ADD,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ sv/lcsa_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module lcsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/lcsa_div.sv @@
// Restoring serial divider: unsigned window sum by fill count, one bit per cycle.
`default_nettype none

module lcsa_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [lcsa_pkg::SUM_W-1:0]    dividend,
    input  wire logic [lcsa_pkg::CNT_W-1:0]    divisor,
    output logic                               done,
    output logic      [lcsa_pkg::FORCE_W-1:0]  quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lcsa_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [lcsa_pkg::SUM_W-1:0]    quo_reg, quo_next;
    logic [lcsa_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [lcsa_pkg::CNT_W-1:0]    div_reg, div_next;
    logic [lcsa_pkg::CNT_W:0]      trial;
    logic                          fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[lcsa_pkg::SUM_W-1]};
        fits      = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = lcsa_pkg::DCNT_W'(lcsa_pkg::DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            // The dividend shifts out of the top as quotient bits shift in below.
            quo_next = {quo_reg[lcsa_pkg::SUM_W-2:0], fits};
            rem_next = fits ? lcsa_pkg::CNT_W'(trial - {1'b0, div_reg})
                            : lcsa_pkg::CNT_W'(trial);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lcsa_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[lcsa_pkg::FORCE_W-1:0];

endmodule

`default_nettype wire

@@ sv/loadcell_scale_and_average.sv @@
// Top level: load cell force scaling with a windowed moving average.
`default_nettype none

// Each item carries a signed 24-bit converter count and an operation bit. The
// block subtracts the zero offset, multiplies by the Q8.24 scale in a serial
// shift-add multiplier that takes one bit of the count per cycle, and
// saturates the result to a Q16.16 force. A plain read returns the force
// with the current average. An update with a window of two or more also
// stores the force in a 64-entry ring memory, updates the running sum and
// runs a restoring divider that produces one quotient bit per cycle. Those
// two serial units set the item time. One finished result may wait in the
// output register while the next item is being worked on. A write to
// window_size restarts the average; the ring needs no clearing pass because
// only entries written since the restart are ever read.
module loadcell_scale_and_average (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lcsa_pkg::RAW_W-1:0]       s_raw_count,
    input  wire logic                             s_operation,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [lcsa_pkg::FORCE_W-1:0]     m_force_res,
    output logic      [lcsa_pkg::FORCE_W-1:0]     m_filtered_force,
    input  wire logic                             cfg_wr_en,
    input  wire logic [lcsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    lcsa_pkg::state_t state_reg, state_next;

    logic [lcsa_pkg::RAW_W-1:0]   zero_reg, zero_next;
    logic [lcsa_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [lcsa_pkg::WIN_W-1:0]   window_reg, window_next;

    logic                         op_reg, op_next;
    logic [lcsa_pkg::ACC_W-1:0]   hi_reg, hi_next;
    logic [lcsa_pkg::DIFF_W-1:0]  lo_reg, lo_next;
    logic [lcsa_pkg::MCNT_W-1:0]  mcnt_reg, mcnt_next;
    logic [lcsa_pkg::FORCE_W-1:0] force_reg, force_next;
    logic [lcsa_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [lcsa_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [lcsa_pkg::ADDR_W-1:0]  slot_reg, slot_next;
    logic [lcsa_pkg::FORCE_W-1:0] avg_reg, avg_next;
    logic                         neg_reg, neg_next;

    logic                         m_valid_reg, m_valid_next;
    logic [lcsa_pkg::FORCE_W-1:0] m_force_reg, m_force_next;
    logic [lcsa_pkg::FORCE_W-1:0] m_filt_reg, m_filt_next;

    logic [lcsa_pkg::CNT_W-1:0]   w_eff;
    logic [lcsa_pkg::ACC_W-1:0]   scale_ext;
    logic [lcsa_pkg::ACC_W-1:0]   addend;
    logic [lcsa_pkg::ACC_W-1:0]   acc_sum;
    logic [lcsa_pkg::Q_W-1:0]     q_full;
    logic                         q_ovf;
    logic [lcsa_pkg::FORCE_W-1:0] force_sat;
    logic [lcsa_pkg::CNT_W-1:0]   slot_inc;

    logic                         ram_we;
    logic [lcsa_pkg::FORCE_W-1:0] ram_rdata;

    logic                         div_start;
    logic [lcsa_pkg::SUM_W-1:0]   div_dividend;
    logic                         div_done;
    logic [lcsa_pkg::FORCE_W-1:0] div_quotient;

    lcsa_ram #(
        .WIDTH (lcsa_pkg::FORCE_W),
        .DEPTH (lcsa_pkg::MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_reg),
        .wr_data (force_reg),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    lcsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        if ({{(32-lcsa_pkg::WIN_W){1'b0}}, window_reg} > 32'(lcsa_pkg::MAX_WINDOW)) begin
            w_eff = lcsa_pkg::CNT_W'(lcsa_pkg::MAX_WINDOW);
        end else begin
            w_eff = lcsa_pkg::CNT_W'(window_reg);
        end
    end

    // Shift-add step: the low bit of the count selects the scale; the count's
    // sign bit comes last and carries a negative weight.
    assign scale_ext = {{(lcsa_pkg::ACC_W-lcsa_pkg::SCALE_W){scale_reg[lcsa_pkg::SCALE_W-1]}},
                        scale_reg};
    assign addend    = !lo_reg[0] ? '0 :
                       (mcnt_reg == lcsa_pkg::MCNT_W'(1)) ? (~scale_ext + 1'b1) : scale_ext;
    assign acc_sum   = hi_reg + addend;

    // The full product is {hi, lo}; dropping the low bits is a floor division.
    assign q_full    = {hi_reg, lo_reg[lcsa_pkg::DIFF_W-1:lcsa_pkg::FRAC_SHIFT]};
    assign q_ovf     = !((&q_full[lcsa_pkg::Q_W-1:lcsa_pkg::FORCE_W-1]) ||
                         (~|q_full[lcsa_pkg::Q_W-1:lcsa_pkg::FORCE_W-1]));
    assign force_sat = !q_ovf ? q_full[lcsa_pkg::FORCE_W-1:0] :
                       q_full[lcsa_pkg::Q_W-1] ? lcsa_pkg::FORCE_MIN : lcsa_pkg::FORCE_MAX;

    assign slot_inc  = {1'b0, slot_reg} + 1'b1;
    assign div_dividend = sum_reg[lcsa_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_comb begin
        state_next   = state_reg;
        zero_next    = zero_reg;
        scale_next   = scale_reg;
        window_next  = window_reg;
        op_next      = op_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        mcnt_next    = mcnt_reg;
        force_next   = force_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        avg_next     = avg_reg;
        neg_next     = neg_reg;
        m_force_next = m_force_reg;
        m_filt_next  = m_filt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;

        case (state_reg)
            lcsa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_operation;
                    hi_next    = '0;
                    lo_next    = {s_raw_count[lcsa_pkg::RAW_W-1], s_raw_count}
                               - {zero_reg[lcsa_pkg::RAW_W-1], zero_reg};
                    mcnt_next  = lcsa_pkg::MCNT_W'(lcsa_pkg::MUL_STEPS);
                    state_next = lcsa_pkg::ST_MUL;
                end
            end
            lcsa_pkg::ST_MUL: begin
                hi_next   = {acc_sum[lcsa_pkg::ACC_W-1], acc_sum[lcsa_pkg::ACC_W-1:1]};
                lo_next   = {acc_sum[0], lo_reg[lcsa_pkg::DIFF_W-1:1]};
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == lcsa_pkg::MCNT_W'(1)) begin
                    state_next = lcsa_pkg::ST_SAT;
                end
            end
            lcsa_pkg::ST_SAT: begin
                force_next = force_sat;
                if (!op_reg) begin
                    state_next = lcsa_pkg::ST_OUT;
                end else if (w_eff <= lcsa_pkg::CNT_W'(1)) begin
                    avg_next   = force_sat;
                    state_next = lcsa_pkg::ST_OUT;
                end else begin
                    // The ring entry at the write slot is read during this cycle.
                    state_next = lcsa_pkg::ST_SUB;
                end
            end
            lcsa_pkg::ST_SUB: begin
                if (fill_reg >= w_eff) begin
                    sum_next  = sum_reg - {{(lcsa_pkg::SUM_W-lcsa_pkg::FORCE_W)
                                           {ram_rdata[lcsa_pkg::FORCE_W-1]}}, ram_rdata};
                    fill_next = w_eff;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = lcsa_pkg::ST_ADD;
            end
            lcsa_pkg::ST_ADD: begin
                sum_next  = sum_reg + {{(lcsa_pkg::SUM_W-lcsa_pkg::FORCE_W)
                                        {force_reg[lcsa_pkg::FORCE_W-1]}}, force_reg};
                ram_we    = 1'b1;
                slot_next = (slot_inc == w_eff) ? '0 : slot_inc[lcsa_pkg::ADDR_W-1:0];
                state_next = lcsa_pkg::ST_DSTART;
            end
            lcsa_pkg::ST_DSTART: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[lcsa_pkg::SUM_W-1];
                state_next = lcsa_pkg::ST_DIV;
            end
            lcsa_pkg::ST_DIV: begin
                if (div_done) begin
                    avg_next   = neg_reg ? (~div_quotient + 1'b1) : div_quotient;
                    state_next = lcsa_pkg::ST_OUT;
                end
            end
            lcsa_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_force_next = force_reg;
                    m_filt_next  = avg_reg;
                    state_next   = lcsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcsa_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            case (cfg_index)
                lcsa_pkg::REG_ZERO_OFFSET: begin
                    zero_next = cfg_wdata[lcsa_pkg::RAW_W-1:0];
                end
                lcsa_pkg::REG_SCALE_FACTOR: begin
                    scale_next = cfg_wdata[lcsa_pkg::SCALE_W-1:0];
                end
                lcsa_pkg::REG_WINDOW_SIZE: begin
                    window_next = cfg_wdata[lcsa_pkg::WIN_W-1:0];
                    sum_next    = '0;
                    fill_next   = '0;
                    slot_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcsa_pkg::ST_IDLE;
            zero_reg    <= '0;
            scale_reg   <= lcsa_pkg::SCALE_RESET;
            window_reg  <= lcsa_pkg::WINDOW_RESET;
            mcnt_reg    <= '0;
            sum_reg     <= '0;
            fill_reg    <= '0;
            slot_reg    <= '0;
            avg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            zero_reg    <= zero_next;
            scale_reg   <= scale_next;
            window_reg  <= window_next;
            mcnt_reg    <= mcnt_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            slot_reg    <= slot_next;
            avg_reg     <= avg_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        force_reg   <= force_next;
        neg_reg     <= neg_next;
        m_force_reg <= m_force_next;
        m_filt_reg  <= m_filt_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_force_res      = m_force_reg;
    assign m_filtered_force = m_filt_reg;

endmodule

`default_nettype wire
